>>> hw/rtl/glmf_pkg.sv
// ----------------------------------------------------------------------------
// glmf_pkg
// Shared widths, register indexes and the result record of the grid local
// maximum finder.
// ----------------------------------------------------------------------------
package glmf_pkg;

  // fixed field widths
  localparam int ROW_W         = 12;
  localparam int COL_W         = 8;
  localparam int GRID_WIDTH_W  = 9;
  localparam int GRID_HEIGHT_W = 13;
  localparam int MAX_HEIGHT    = 4096;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // result queue
  localparam int MAX_RESULTS = 3;
  localparam int RES_CNT_W   = 2;

  typedef struct packed {
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic             is_peak;
    logic             last_of_run;
    logic             frame_end;
  } result_t;

endpackage

>>> hw/rtl/glmf_in_if.sv
// ----------------------------------------------------------------------------
// glmf_in_if
// Sample stream channel: valid, ready and one signed elevation per item.
// ----------------------------------------------------------------------------
interface glmf_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] elevation;

  modport source (output valid, output elevation, input ready);
  modport sink   (input valid, input elevation, output ready);
endinterface

>>> hw/rtl/glmf_out_if.sv
// ----------------------------------------------------------------------------
// glmf_out_if
// Decision channel: valid, ready and one decided cell per item.
// ----------------------------------------------------------------------------
interface glmf_out_if
  import glmf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] cell_row;
  logic [COL_W-1:0] cell_col;
  logic             is_peak;
  logic             last_of_run;
  logic             frame_end;

  modport source (output valid, output cell_row, output cell_col, output is_peak,
                  output last_of_run, output frame_end, input ready);
  modport sink   (input valid, input cell_row, input cell_col, input is_peak,
                  input last_of_run, input frame_end, output ready);
endinterface

>>> hw/rtl/glmf_cfg_if.sv
// ----------------------------------------------------------------------------
// glmf_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface glmf_cfg_if
  import glmf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/glmf_cell.sv
// ----------------------------------------------------------------------------
// glmf_cell
// One line buffer cell: holds one sample and, on each accepted item, loads
// either the new sample (when it is the entry cell for the current width)
// or the sample of its upper neighbor.
// ----------------------------------------------------------------------------
module glmf_cell #(
  parameter int IDX_W       = 8,
  parameter int INDEX       = 0,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic [IDX_W-1:0]       w_last,
  input  logic [SAMPLE_BITS-1:0] entry_d,
  input  logic [SAMPLE_BITS-1:0] chain_d,
  output logic [SAMPLE_BITS-1:0] q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [SAMPLE_BITS-1:0] q_r;
  logic [SAMPLE_BITS-1:0] q_nxt;

  // entry point sits at the last column of the configured row
  assign q_nxt = (w_last == MY_IDX) ? entry_d : chain_d;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

>>> hw/rtl/glmf_line.sv
// ----------------------------------------------------------------------------
// glmf_line
// Variable length line buffer built as a chain of cells. Samples enter at
// the cell of the last column and move one cell toward cell 0 per item, so
// cell 0 holds the sample of one row ago and cell 1 the one after it.
// ----------------------------------------------------------------------------
module glmf_line #(
  parameter int MAX_WIDTH   = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int TAPS        = 1,
  parameter int IDX_W       = 8
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic [IDX_W-1:0]       w_last,
  input  logic [SAMPLE_BITS-1:0] din,
  output logic [SAMPLE_BITS-1:0] taps_o [TAPS]
);

  logic [SAMPLE_BITS-1:0] cell_q [MAX_WIDTH];

  // row of cells
  for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_cell
    if (j == MAX_WIDTH - 1) begin : g_top
      glmf_cell #(
        .IDX_W      (IDX_W),
        .INDEX      (j),
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk     (clk),
        .shift_en(shift_en),
        .w_last  (w_last),
        .entry_d (din),
        .chain_d (din),
        .q       (cell_q[j])
      );
    end else begin : g_mid
      glmf_cell #(
        .IDX_W      (IDX_W),
        .INDEX      (j),
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk     (clk),
        .shift_en(shift_en),
        .w_last  (w_last),
        .entry_d (din),
        .chain_d (cell_q[j+1]),
        .q       (cell_q[j])
      );
    end
  end

  // head taps
  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    assign taps_o[t] = cell_q[t];
  end

endmodule

>>> hw/rtl/glmf_res_queue.sv
// ----------------------------------------------------------------------------
// glmf_res_queue
// Three slot result queue that doubles as the output register. Slot 0 drives
// the decision channel; the user must load a new batch only when the queue is
// empty or empties in the same cycle; the queue does not enforce this.
// ----------------------------------------------------------------------------
module glmf_res_queue
  import glmf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic [RES_CNT_W-1:0] load_cnt,
  input  result_t              load_data [MAX_RESULTS],
  output logic                 can_load,
  glmf_out_if.source           out_m
);

  result_t              q_r   [MAX_RESULTS];
  result_t              q_nxt [MAX_RESULTS];
  logic [RES_CNT_W-1:0] cnt_r;
  logic [RES_CNT_W-1:0] cnt_nxt;
  logic                 pop;

  assign pop      = out_m.valid && out_m.ready;
  assign can_load = (cnt_r == '0) || ((cnt_r == RES_CNT_W'(1)) && out_m.ready);

  // shift on pop, reload on a new item
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      cnt_nxt = cnt_r - RES_CNT_W'(1);
    end
    if (load) begin
      q_nxt   = load_data;
      cnt_nxt = load_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // output channel
  assign out_m.valid       = (cnt_r != '0);
  assign out_m.cell_row    = q_r[0].cell_row;
  assign out_m.cell_col    = q_r[0].cell_col;
  assign out_m.is_peak     = q_r[0].is_peak;
  assign out_m.last_of_run = q_r[0].last_of_run;
  assign out_m.frame_end   = q_r[0].frame_end;

endmodule

>>> hw/rtl/grid_local_maximum_finder.sv
// ----------------------------------------------------------------------------
// grid_local_maximum_finder
// Four neighbor local maximum detection over a raster stream of elevations.
//
//   channel  dir  handshake            payload
//   in_s     in   valid/ready          elevation
//   out_m    out  valid/ready          cell_row, cell_col, is_peak,
//                                      last_of_run, frame_end
//   cfg_s    in   valid/ready (=1)     index, data
//
// One item per cycle for rows 0 to height-2 while the output is not stalled
// (one or no result per item). In the last row the item in column 0 gives one
// result, every later item two and the final one three; the single result
// port drains the three slot result queue at one per cycle unless stalled.
// Reset is synchronous: it clears position, queue and the left samples and
// sets width (capped at MAX_WIDTH) and height to 20. The line buffers need no
// clearing pass. A stalled result holds in the queue; a new item is taken when
// the queue is empty or in the cycle in which it empties.
// ----------------------------------------------------------------------------
module grid_local_maximum_finder
  import glmf_pkg::*;
#(
  parameter int MAX_WIDTH   = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  glmf_in_if.sink    in_s,
  glmf_out_if.source out_m,
  glmf_cfg_if.sink   cfg_s
);

  localparam int CW          = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RST_W_LAST  = (20 > MAX_WIDTH) ? MAX_WIDTH - 1 : 19;
  localparam int RST_H_LAST  = 19;

  logic [CW-1:0]          w_last_r;
  logic [CW-1:0]          w_last_nxt;
  logic [ROW_W-1:0]       h_last_r;
  logic [ROW_W-1:0]       h_last_nxt;
  logic [ROW_W-1:0]       row_r;
  logic [ROW_W-1:0]       row_nxt;
  logic [CW-1:0]          col_r;
  logic [CW-1:0]          col_nxt;
  logic [SAMPLE_BITS-1:0] left_r;
  logic [SAMPLE_BITS-1:0] left2_r;
  logic [SAMPLE_BITS-1:0] up_left_r;

  logic                   accept;
  logic                   cfg_wr;
  logic                   can_load;
  logic [SAMPLE_BITS-1:0] prev_taps  [2];
  logic [SAMPLE_BITS-1:0] prev2_taps [1];

  logic signed [SAMPLE_BITS-1:0] v_s;
  logic signed [SAMPLE_BITS-1:0] self_up_s;
  logic signed [SAMPLE_BITS-1:0] right_up_s;
  logic signed [SAMPLE_BITS-1:0] up_up_s;
  logic signed [SAMPLE_BITS-1:0] up_left_s;
  logic signed [SAMPLE_BITS-1:0] left_s;
  logic signed [SAMPLE_BITS-1:0] left2_s;

  logic                 last_row;
  logic                 last_col;
  logic                 above_en;
  logic                 left_en;
  logic                 self_en;
  logic                 col_ge2;
  logic                 row_ge2;
  result_t              cand      [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] cand_en;
  result_t              load_data [MAX_RESULTS];
  logic [RES_CNT_W-1:0] load_cnt;

  assign accept      = in_s.valid && in_s.ready;
  assign in_s.ready  = can_load;
  assign cfg_s.ready = 1'b1;
  assign cfg_wr      = cfg_s.valid && cfg_s.ready &&
                       ((cfg_s.index == REG_GRID_WIDTH) || (cfg_s.index == REG_GRID_HEIGHT));

  // clamped last column and last row from register writes
  always_comb begin
    int wv;
    int hv;
    wv         = int'(cfg_s.data[GRID_WIDTH_W-1:0]);
    hv         = int'(cfg_s.data[GRID_HEIGHT_W-1:0]);
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    if (cfg_s.valid && (cfg_s.index == REG_GRID_WIDTH)) begin
      if (wv < 2) begin
        w_last_nxt = CW'(1);
      end else if (wv > MAX_WIDTH) begin
        w_last_nxt = CW'(MAX_WIDTH - 1);
      end else begin
        w_last_nxt = CW'(wv - 1);
      end
    end
    if (cfg_s.valid && (cfg_s.index == REG_GRID_HEIGHT)) begin
      if (hv < 2) begin
        h_last_nxt = ROW_W'(1);
      end else if (hv > MAX_HEIGHT) begin
        h_last_nxt = ROW_W'(MAX_HEIGHT - 1);
      end else begin
        h_last_nxt = ROW_W'(hv - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= CW'(RST_W_LAST);
      h_last_r <= ROW_W'(RST_H_LAST);
    end else begin
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
    end
  end

  // raster position of the next item
  assign last_col = (col_r == w_last_r);
  assign last_row = (row_r == h_last_r);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      left_r  <= '0;
      left2_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (accept) begin
        left_r  <= in_s.elevation;
        left2_r <= left_r;
      end
    end
  end

  // left neighbor of the cell above: the sample leaving the first line
  always_ff @(posedge clk) begin
    if (accept) begin
      up_left_r <= prev_taps[0];
    end
  end

  // line buffers: previous row and the row before it
  glmf_line #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .TAPS       (2),
    .IDX_W      (CW)
  ) u_prev_line (
    .clk     (clk),
    .shift_en(accept),
    .w_last  (w_last_r),
    .din     (in_s.elevation),
    .taps_o  (prev_taps)
  );

  glmf_line #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS),
    .TAPS       (1),
    .IDX_W      (CW)
  ) u_prev2_line (
    .clk     (clk),
    .shift_en(accept),
    .w_last  (w_last_r),
    .din     (prev_taps[0]),
    .taps_o  (prev2_taps)
  );

  // neighbor window
  assign v_s        = $signed(in_s.elevation);
  assign self_up_s  = $signed(prev_taps[0]);
  assign right_up_s = $signed(prev_taps[1]);
  assign up_up_s    = $signed(prev2_taps[0]);
  assign up_left_s  = $signed(up_left_r);
  assign left_s     = $signed(left_r);
  assign left2_s    = $signed(left2_r);

  assign row_ge2  = (row_r != '0) && (row_r != ROW_W'(1));
  assign col_ge2  = (col_r != '0) && (col_r != CW'(1));
  assign above_en = (row_r != '0);
  assign left_en  = last_row && (col_r != '0);
  assign self_en  = last_row && last_col;
  assign cand_en  = {self_en, left_en, above_en};

  // candidate decisions: cell above, cell to the left, own cell
  always_comb begin
    cand[0].cell_row    = row_r - ROW_W'(1);
    cand[0].cell_col    = COL_W'(col_r);
    cand[0].is_peak     = (self_up_s >= v_s) &&
                          (!row_ge2 || (self_up_s >= up_up_s)) &&
                          ((col_r == '0) || (self_up_s >= up_left_s)) &&
                          (last_col || (self_up_s >= right_up_s));
    cand[0].last_of_run = !left_en && !self_en;
    cand[0].frame_end   = 1'b0;

    cand[1].cell_row    = row_r;
    cand[1].cell_col    = COL_W'(col_r - CW'(1));
    cand[1].is_peak     = (left_s >= v_s) && (left_s >= up_left_s) &&
                          (!col_ge2 || (left_s >= left2_s));
    cand[1].last_of_run = !self_en;
    cand[1].frame_end   = 1'b0;

    cand[2].cell_row    = row_r;
    cand[2].cell_col    = COL_W'(col_r);
    cand[2].is_peak     = (v_s >= self_up_s) && (v_s >= left_s);
    cand[2].last_of_run = 1'b1;
    cand[2].frame_end   = 1'b1;
  end

  // pack enabled candidates into queue order
  always_comb begin
    load_data = cand;
    load_cnt  = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (cand_en[i]) begin
        load_data[load_cnt] = cand[i];
        load_cnt            = load_cnt + RES_CNT_W'(1);
      end
    end
  end

  glmf_res_queue u_res_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .load_cnt (load_cnt),
    .load_data(load_data),
    .can_load (can_load),
    .out_m    (out_m)
  );

endmodule

>>> hw/rtl/glmf_checker.sv
// ----------------------------------------------------------------------------
// glmf_port_checks
// Port level checks of the grid local maximum finder, bound to the top.
// ----------------------------------------------------------------------------
module glmf_port_checks
  import glmf_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ROW_W-1:0] out_cell_row,
  input logic [COL_W-1:0] out_cell_col,
  input logic             out_is_peak,
  input logic             out_last_of_run,
  input logic             out_frame_end
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_row) &&
      $stable(out_cell_col) && $stable(out_is_peak) &&
      $stable(out_last_of_run) && $stable(out_frame_end))
    else $error("stalled result changed");

  // no new item while a result is stuck at the output
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while output stalled");

  // the frame's last decision closes its run
  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_last_of_run)
    else $error("frame end without end of run");

endmodule

bind grid_local_maximum_finder glmf_port_checks u_glmf_port_checks (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_s.ready),
  .out_valid      (out_m.valid),
  .out_ready      (out_m.ready),
  .out_cell_row   (out_m.cell_row),
  .out_cell_col   (out_m.cell_col),
  .out_is_peak    (out_m.is_peak),
  .out_last_of_run(out_m.last_of_run),
  .out_frame_end  (out_m.frame_end)
);
